>>> hdl/tfu_pkg.sv
package tfu_pkg;

	// frame geometry
	localparam int FRAME_LEN = 11;
	localparam int POS_BITS = $clog2(FRAME_LEN + 1);
	// position counter is at least as wide as the 4-bit index port
	localparam int POS_W = (POS_BITS > 4) ? POS_BITS : 4;

	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_LEN);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0] KIND_SLOT = POS_W'(1);

	// special bytes
	localparam logic [7:0] DELIM = 8'h7E;
	localparam logic [7:0] ESCAPE = 8'h7D;
	localparam logic [7:0] ESC_DELIM = 8'h5E;
	localparam logic [7:0] ESC_ESCAPE = 8'h5D;

	// config register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_TYPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USER_TYPE = 1'd1;

	localparam logic [7:0] LINK_TYPE_RESET = 8'hFE;
	localparam logic [7:0] USER_TYPE_RESET = 8'hFD;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_DELIM  = 2'd1,
		PH_READ   = 2'd2,
		PH_ESCAPE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_LINK    = 2'd1,
		KIND_USER    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] link_type;
		logic [7:0] user_type;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] index;
		logic       frame_end;
		kind_t      kind;
		logic       overflow;
	} result_t;

endpackage

>>> hdl/tfu_cfg_regs.sv
module tfu_cfg_regs
	import tfu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output cfg_t                 cfg
);

	logic [7:0] link_type_q;
	logic [7:0] user_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= LINK_TYPE_RESET;
			user_type_q <= USER_TYPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINK_TYPE: link_type_q <= cfg_data;
				REG_USER_TYPE: user_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.link_type = link_type_q;
	assign cfg.user_type = user_type_q;

endmodule

>>> hdl/tfu_deframe.sv
module tfu_deframe
	import tfu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_word,
	input  cfg_t       cfg,
	output logic       emit,
	output result_t    res
);

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	kind_t             kind_q, kind_d;
	logic              ovf_q, ovf_d;

	logic              restart;
	logic [7:0]        data;
	logic              end_flag;
	logic [POS_W-1:0]  base_pos;
	kind_t             base_kind;
	logic              base_ovf;
	logic              full;
	logic [POS_W-1:0]  slot;
	kind_t             class_kind;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SEARCH: begin
				if (rx_word == DELIM) phase_d = PH_DELIM;
			end
			PH_DELIM: begin
				if (rx_word != DELIM) phase_d = PH_READ;
			end
			PH_READ: begin
				if (rx_word == ESCAPE) phase_d = PH_ESCAPE;
				else if (rx_word == DELIM) phase_d = PH_DELIM;
			end
			PH_ESCAPE: begin
				if (rx_word == ESC_DELIM || rx_word == ESC_ESCAPE) phase_d = PH_READ;
				else phase_d = PH_SEARCH;
			end
			default: phase_d = PH_SEARCH;
		endcase
	end

	// per-phase outputs
	always_comb begin
		restart = 1'b0;
		data = rx_word;
		end_flag = 1'b0;
		unique case (phase_q)
			PH_SEARCH: ;
			PH_DELIM: restart = (rx_word == DELIM);
			PH_READ: end_flag = (rx_word == DELIM);
			PH_ESCAPE: begin
				if (rx_word == ESC_DELIM) data = DELIM;
				else if (rx_word == ESC_ESCAPE) data = ESCAPE;
			end
			default: ;
		endcase
	end

	// escape byte is swallowed
	assign emit = (phase_d != PH_ESCAPE);

	assign base_pos  = restart ? '0 : pos_q;
	assign base_kind = restart ? KIND_UNKNOWN : kind_q;
	assign base_ovf  = restart ? 1'b0 : ovf_q;
	assign full      = (base_pos >= POS_LIMIT);
	assign slot      = full ? POS_LAST : base_pos;

	always_comb begin
		priority if (data == cfg.link_type) class_kind = KIND_LINK;
		else if (data == cfg.user_type) class_kind = KIND_USER;
		else class_kind = KIND_UNKNOWN;
	end

	always_comb begin
		pos_d = base_pos;
		kind_d = base_kind;
		ovf_d = base_ovf;
		if (emit) begin
			if (full) begin
				ovf_d = 1'b1;
			end else begin
				pos_d = base_pos + POS_W'(1);
				if (base_pos == KIND_SLOT) kind_d = class_kind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			pos_q <= '0;
			kind_q <= KIND_UNKNOWN;
			ovf_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			kind_q <= kind_d;
			ovf_q <= ovf_d;
		end
	end

	assign res.data = data;
	assign res.index = slot[3:0];
	assign res.frame_end = end_flag;
	assign res.kind = kind_d;
	assign res.overflow = ovf_d;

endmodule

>>> hdl/telemetry_frame_unstuffer_top.sv
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall   | rx_byte
// output  | out       | out_valid / out_stall | out_byte, byte_index, frame_end, frame_kind,
//         |           |                       | overflow
// config  | in        | cfg_we                | cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low; each result is registered before output
// path: input register, deframer logic, result register
// reset puts the deframer in delimiter search with an empty frame and the type codes at default
// input stall rises only while a word in the input register has a result and the result
// register is full and stalled
module telemetry_frame_unstuffer_top
	import tfu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic [3:0]           byte_index,
	output logic                 frame_end,
	output logic [1:0]           frame_kind,
	output logic                 overflow,
	// config write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       emit;
	result_t    res;
	logic       advance;
	logic       in_take;
	logic       out_valid_q;
	result_t    res_q;

	tfu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the held word moves on when its result has room or it gives none
	assign advance = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	tfu_deframe u_deframe (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_word (byte_s1),
		.cfg     (cfg),
		.emit    (emit),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = res_q.data;
	assign byte_index = res_q.index;
	assign frame_end  = res_q.frame_end;
	assign frame_kind = res_q.kind;
	assign overflow   = res_q.overflow;

endmodule
